[src/dwct_pkg.sv]
// package for the delay window centering trainer
// holds widths, codes, phase and kind types and the result word layout
// no dependencies

`default_nettype none

package dwct_pkg;

    // delay code and counter widths
    localparam int DELAY_BITS = 5;
    localparam int COUNT_BITS = 7;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // register reset values
    localparam logic [DELAY_BITS-1:0] RANGE_LO_RESET = '0;
    localparam logic [DELAY_BITS-1:0] RANGE_HI_RESET = {DELAY_BITS{1'b1}};

    // configuration port layout
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic REG_RANGE_LO = 1'b0;
    localparam logic REG_RANGE_HI = 1'b1;

    // input word layout
    localparam int IN_TDATA_BITS = 8;
    localparam int IN_TUSER_BITS = 1;
    localparam logic ACT_START    = 1'b0;
    localparam logic ACT_RESPONSE = 1'b1;

    // output word layout
    localparam int KIND_BITS      = 2;
    localparam int OUT_DATA_BITS  = 4 * DELAY_BITS + COUNT_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_DATA_BITS;

    // training phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PROBE,
        PH_LEFT,
        PH_RIGHT
    } t_phase;

    // result word kind
    typedef enum logic [KIND_BITS-1:0] {
        KIND_QUERY,
        KIND_DONE,
        KIND_FAIL,
        KIND_IGNORED
    } t_kind;

    // one result word
    typedef struct packed {
        t_kind                  kind;
        logic [COUNT_BITS-1:0]  query_total;
        logic [DELAY_BITS-1:0]  center_delay;
        logic [DELAY_BITS-1:0]  right_edge;
        logic [DELAY_BITS-1:0]  left_edge;
        logic [DELAY_BITS-1:0]  query_delay;
    } t_result;

endpackage

`default_nettype wire

[src/delay_window_centering_trainer_core.sv]
// Delay window centering trainer: every accepted word yields exactly one result word, held
// in the output register or, while the output stalls, in the skid entry. The whole step
// (probe move, binary search bound update, search hand-over and final centering) is a few
// narrow compares and adds evaluated in the cycle the word is accepted, so the rate is one
// word per clock while the skid entry is empty, set by that single step of logic between
// the state registers and the output register. The output side has a register plus one
// skid entry; s_axis_tready drops only while both hold words that the sink has not taken.
// The range bounds are taken at start, and the upper bound is read again when the right
// edge search begins. No clearing pass after reset.
// depends on dwct_pkg

`default_nettype none

module delay_window_centering_trainer_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [dwct_pkg::IN_TDATA_BITS-1:0] s_axis_tdata,  // [0] passed, rest zero
    input  wire logic [dwct_pkg::IN_TUSER_BITS-1:0] s_axis_tuser,  // [0] action
    // output stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // query_delay, left_edge, right_edge, center_delay, query_total, zero pad
    output logic [dwct_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata,
    output logic [dwct_pkg::KIND_BITS-1:0]          m_axis_tuser,  // kind
    // configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [dwct_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [dwct_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [dwct_pkg::APB_DATA_BITS-1:0]      prdata,
    output logic                                    pready
);

    import dwct_pkg::*;

    // midpoint rounded down
    function automatic logic [DELAY_BITS-1:0] mid_down(input logic [DELAY_BITS-1:0] lo,
                                                       input logic [DELAY_BITS-1:0] hi);
        logic [DELAY_BITS-1:0] span;
        span = hi - lo;
        return lo + (span >> 1);
    endfunction

    // midpoint rounded up
    function automatic logic [DELAY_BITS-1:0] mid_up(input logic [DELAY_BITS-1:0] lo,
                                                     input logic [DELAY_BITS-1:0] hi);
        logic [DELAY_BITS:0] span;
        span = {1'b0, hi} - {1'b0, lo} + {{DELAY_BITS{1'b0}}, 1'b1};
        return lo + span[DELAY_BITS:1];
    endfunction

    // configuration registers
    logic [DELAY_BITS-1:0] r_min;
    logic [DELAY_BITS-1:0] r_max;

    // training state
    t_phase                r_phase, n_phase;
    logic [DELAY_BITS-1:0] r_low, n_low;
    logic [DELAY_BITS-1:0] r_high, n_high;
    logic [DELAY_BITS-1:0] r_center, n_center;
    logic [DELAY_BITS-1:0] r_offset, n_offset;
    logic                  r_upper, n_upper;
    logic [DELAY_BITS-1:0] r_pending, n_pending;
    logic [DELAY_BITS-1:0] r_known, n_known;
    logic [DELAY_BITS-1:0] r_left, n_left;
    logic [COUNT_BITS-1:0] r_count, n_count;

    // output register and skid entry
    logic                  r_out_valid;
    t_result               r_out;
    logic                  r_skid_valid;
    t_result               r_skid;

    // step evaluation
    logic                  w_accept;
    logic                  w_take;
    logic                  w_action;
    logic                  w_passed;
    t_result               w_res;
    logic                  w_run_left;
    logic                  w_run_right;
    logic                  w_enter_left;
    logic                  w_enter_right;
    logic [DELAY_BITS-1:0] w_off_inc;
    logic [DELAY_BITS:0]   w_low_plus;

    assign w_action = s_axis_tuser[0];
    assign w_passed = s_axis_tdata[0];
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_take   = m_axis_tvalid && m_axis_tready;

    // configuration write and read back
    assign pready = 1'b1;
    assign prdata = {{(APB_DATA_BITS-DELAY_BITS){1'b0}},
                     (paddr[2] == REG_RANGE_HI) ? r_max : r_min};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= RANGE_LO_RESET;
            r_max <= RANGE_HI_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_RANGE_LO) begin
                r_min <= pwdata[DELAY_BITS-1:0];
            end else begin
                r_max <= pwdata[DELAY_BITS-1:0];
            end
        end
    end

    // one training step for the word on the input
    always_comb begin : step_eval
        n_low         = r_low;
        n_high        = r_high;
        n_center      = r_center;
        n_offset      = r_offset;
        n_upper       = r_upper;
        n_pending     = r_pending;
        n_known       = r_known;
        n_left        = r_left;
        n_count       = r_count;
        w_res         = '0;
        w_res.kind    = KIND_QUERY;
        w_run_left    = 1'b0;
        w_run_right   = 1'b0;
        w_enter_left  = 1'b0;
        w_enter_right = 1'b0;
        w_off_inc     = r_offset + {{(DELAY_BITS-1){1'b0}}, 1'b1};
        w_low_plus    = {1'b0, r_low} + {1'b0, w_off_inc};

        if (w_action == ACT_START) begin
            // new session, ask the middle of the range
            n_count = '0;
            if (r_max < r_min) begin
                w_res.kind = KIND_FAIL;
            end else begin
                n_low             = r_min;
                n_high            = r_max;
                n_center          = mid_down(r_min, r_max);
                n_offset          = '0;
                n_upper           = 1'b0;
                n_pending         = n_center;
                w_res.query_delay = n_center;
            end
        end else if (r_phase == PH_IDLE) begin
            w_res.kind = KIND_IGNORED;
        end else begin
            if (r_count != COUNT_MAX) begin
                n_count = r_count + {{(COUNT_BITS-1){1'b0}}, 1'b1};
            end
            unique case (r_phase)
                PH_PROBE: begin
                    if (w_passed) begin
                        n_known      = r_pending;
                        n_high       = r_pending;
                        w_run_left   = 1'b1;
                        w_enter_left = 1'b1;
                    end else if (!r_upper) begin
                        // same offset on the upper side
                        n_upper           = 1'b1;
                        n_pending         = r_center + r_offset;
                        w_res.query_delay = n_pending;
                    end else begin
                        // step outward, lower side first where it fits
                        n_offset = w_off_inc;
                        n_upper  = 1'b0;
                        if (w_off_inc > (r_high - r_center)) begin
                            w_res.kind = KIND_FAIL;
                        end else if ({1'b0, r_center} >= w_low_plus) begin
                            n_pending         = r_center - w_off_inc;
                            w_res.query_delay = n_pending;
                        end else begin
                            n_upper           = 1'b1;
                            n_pending         = r_center + w_off_inc;
                            w_res.query_delay = n_pending;
                        end
                    end
                end
                PH_LEFT: begin
                    if (w_passed) begin
                        n_high = r_pending;
                    end else begin
                        n_low = r_pending + {{(DELAY_BITS-1){1'b0}}, 1'b1};
                    end
                    w_run_left = 1'b1;
                end
                PH_RIGHT: begin
                    if (w_passed) begin
                        n_low = r_pending;
                    end else begin
                        n_high = r_pending - {{(DELAY_BITS-1){1'b0}}, 1'b1};
                    end
                    w_run_right = 1'b1;
                end
                default: begin
                end
            endcase

            // left edge search step, hand over to the right search when it closes
            if (w_run_left) begin
                if (n_low < n_high) begin
                    n_pending         = mid_down(n_low, n_high);
                    w_res.query_delay = n_pending;
                end else begin
                    n_left        = n_low;
                    n_low         = n_known;
                    n_high        = r_max;
                    w_run_right   = 1'b1;
                    w_enter_right = 1'b1;
                end
            end

            // right edge search step, final result when it closes
            if (w_run_right) begin
                if (n_low < n_high) begin
                    n_pending         = mid_up(n_low, n_high);
                    w_res.query_delay = n_pending;
                end else begin
                    w_res.kind         = KIND_DONE;
                    w_res.left_edge    = n_left;
                    w_res.right_edge   = n_low;
                    w_res.center_delay = mid_down(n_left, n_low);
                end
            end
        end
        w_res.query_total = n_count;
    end

    // next phase
    always_comb begin : phase_next
        n_phase = r_phase;
        if (w_accept) begin
            if (w_action == ACT_START) begin
                n_phase = (w_res.kind == KIND_FAIL) ? PH_IDLE : PH_PROBE;
            end else if (w_res.kind == KIND_DONE || w_res.kind == KIND_FAIL) begin
                n_phase = PH_IDLE;
            end else if (w_enter_right) begin
                n_phase = PH_RIGHT;
            end else if (w_enter_left) begin
                n_phase = PH_LEFT;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    // search datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_low     <= n_low;
            r_high    <= n_high;
            r_center  <= n_center;
            r_offset  <= n_offset;
            r_upper   <= n_upper;
            r_pending <= n_pending;
            r_known   <= n_known;
            r_left    <= n_left;
        end
    end

    // output register and skid valid bits
    assign s_axis_tready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_accept) begin
            if (r_out_valid && !w_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register and skid payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_accept) begin
            if (r_out_valid && !w_take) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    // output word packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {{OUT_PAD_BITS{1'b0}}, r_out.query_total, r_out.center_delay,
                            r_out.right_edge, r_out.left_edge, r_out.query_delay};

endmodule

`default_nettype wire

[src/dwct_checker.sv]
// port level checks for the delay window centering trainer
// bound to delay_window_centering_trainer_core, depends on dwct_pkg

`default_nettype none

module dwct_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tready,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [dwct_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    input wire logic [dwct_pkg::KIND_BITS-1:0]     m_axis_tuser
);

    import dwct_pkg::*;

    logic [DELAY_BITS-1:0] w_left;
    logic [DELAY_BITS-1:0] w_right;
    logic [DELAY_BITS-1:0] w_center;

    assign w_left   = m_axis_tdata[2*DELAY_BITS-1:DELAY_BITS];
    assign w_right  = m_axis_tdata[3*DELAY_BITS-1:2*DELAY_BITS];
    assign w_center = m_axis_tdata[4*DELAY_BITS-1:3*DELAY_BITS];

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output word changed while stalled");

    // every accepted word shows up as a result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted word gave no result");

    // input stalls only behind a pending output word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // center lies inside the trained window
    a_center_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_DONE) |->
            (w_left <= w_center && w_center <= w_right))
        else $error("center outside window");

endmodule

bind delay_window_centering_trainer_core dwct_checker u_dwct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
